// ===== hw/rtl/gtht_pkg.sv =====
// ----------------------------------------------------------------------------
// gtht_pkg
// Shared types, codes and helpers for the generation-tagged handle table.
// ----------------------------------------------------------------------------
package gtht_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 1024;
    localparam int GEN_W               = 16;
    localparam int FIELD_W             = 16;
    localparam int WORD_W              = 32;
    localparam int BIT_W               = 5;
    localparam int LIVE_W              = 11;
    localparam logic [GEN_W-1:0] GEN_MAX_RESET = 16'hFFFF;

    typedef enum logic [2:0] {
        CMD_ALLOC       = 3'd0,
        CMD_FREE        = 3'd1,
        CMD_LOOKUP_HDL  = 3'd2,
        CMD_LOOKUP_SLOT = 3'd3,
        CMD_COUNT       = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_SLOT = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_STALE    = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_ALLOC,
        S_CHECK,
        S_RESP
    } t_state;

    // lowest set bit of a bitmap word
    function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (v[b]) begin
                pos = BIT_W'(b);
            end
        end
        return pos;
    endfunction

endpackage

// ===== hw/rtl/generation_tagged_handle_table.sv =====
// ----------------------------------------------------------------------------
// generation_tagged_handle_table
// Handle allocator with per-slot generation tags, free and lookup checks.
// ----------------------------------------------------------------------------
// Slot state lives in two memories: a valid bitmap of 32-bit rows and a
// generation tag per slot. Allocate scans the bitmap one row per cycle
// through a single find-first unit, from row 0 up to the row that holds the
// lowest free slot; a full table costs the whole scan and answers full.
// Free, lookup by handle and lookup by slot read the memories, then check
// the slot; count answers directly. One beat is handled at a time; a finished
// result sits in the output register while the next beat is accepted.
// After reset the bitmap is cleared one row per cycle, during which no beat
// is accepted; configuration writes are taken at any time.
module generation_tagged_handle_table #(
    parameter int TABLE_DEPTH = gtht_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_command,
    input  logic [31:0] i_handle,
    input  logic [15:0] i_slot_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_handle_out,
    output logic [10:0] o_live_count
);

    localparam int WORD_W  = gtht_pkg::WORD_W;
    localparam int BIT_W   = gtht_pkg::BIT_W;
    localparam int GEN_W   = gtht_pkg::GEN_W;
    localparam int FIELD_W = gtht_pkg::FIELD_W;
    localparam int LIVE_W  = gtht_pkg::LIVE_W;
    localparam int WORDS   = (TABLE_DEPTH + WORD_W - 1) / WORD_W;
    localparam int WA_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SLOT_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int TAIL    = TABLE_DEPTH % WORD_W;
    localparam logic [WA_W-1:0] LAST_WORD = WA_W'(WORDS - 1);
    localparam logic [WORD_W-1:0] LAST_MASK =
        (TAIL == 0) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << TAIL) - 64'd1);
    localparam logic [FIELD_W:0] DEPTH_EXT = (FIELD_W + 1)'(TABLE_DEPTH);

    gtht_pkg::t_state r_state, n_state;

    logic [GEN_W-1:0]   r_gen_max;
    logic [GEN_W-1:0]   r_next_gen;
    logic [CNT_W-1:0]   r_used;

    gtht_pkg::t_cmd     r_cmd;
    logic [FIELD_W-1:0] r_key;
    logic [GEN_W-1:0]   r_key_gen;

    logic [WA_W-1:0]    r_clr_idx;
    logic [WA_W-1:0]    r_scan_idx;
    logic [WA_W-1:0]    r_data_idx;
    logic               r_data_vld;
    logic [WA_W-1:0]    r_found_word;
    logic [BIT_W-1:0]   r_found_bit;
    logic [WORD_W-1:0]  r_found_data;

    logic [WORD_W-1:0]  r_vmem [WORDS];
    logic [GEN_W-1:0]   r_gmem [TABLE_DEPTH];
    logic [WORD_W-1:0]  r_vword;
    logic [GEN_W-1:0]   r_gword;

    gtht_pkg::t_status  r_res_status;
    logic [31:0]        r_res_handle;
    logic               r_out_valid;
    gtht_pkg::t_status  r_out_status;
    logic [31:0]        r_out_handle;
    logic [CNT_W-1:0]   r_out_live;

    logic               in_accept;
    logic               out_free;
    logic [FIELD_W-1:0] in_key;
    logic [WA_W-1:0]    rd_addr;
    logic [WORD_W-1:0]  avail;
    logic               vmem_we;
    logic [WA_W-1:0]    vmem_waddr;
    logic [WORD_W-1:0]  vmem_wdata;
    logic               gmem_we;
    logic [SLOT_W-1:0]  found_slot;
    logic [FIELD_W-1:0] found_slot_f;
    logic               key_bad;
    logic               key_vbit;
    logic               check_ok;
    gtht_pkg::t_status  check_status;
    logic [GEN_W-1:0]   gen_adv;
    logic [CNT_W+LIVE_W-1:0] live_ext;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign in_key    = (gtht_pkg::t_cmd'(i_command) == gtht_pkg::CMD_LOOKUP_SLOT)
                       ? i_slot_index : i_handle[FIELD_W-1:0];
    assign rd_addr   = (r_state == gtht_pkg::S_SCAN) ? r_scan_idx
                       : in_key[BIT_W +: WA_W];

    // free bits of the row under evaluation, slots past the depth count as used
    assign avail = ~r_vword & ((r_data_idx == LAST_WORD) ? LAST_MASK : {WORD_W{1'b1}});

    assign found_slot_f = FIELD_W'({r_found_word, r_found_bit});
    assign found_slot   = found_slot_f[SLOT_W-1:0];
    assign gen_adv      = (r_next_gen >= r_gen_max) ? '0 : r_next_gen + 1'b1;

    assign key_bad  = {1'b0, r_key} >= DEPTH_EXT;
    assign key_vbit = r_vword[r_key[BIT_W-1:0]];
    always_comb begin
        if (key_bad) begin
            check_status = gtht_pkg::ST_BAD_SLOT;
        end else if (!key_vbit) begin
            check_status = gtht_pkg::ST_EMPTY;
        end else if (r_cmd != gtht_pkg::CMD_LOOKUP_SLOT && r_gword != r_key_gen) begin
            check_status = gtht_pkg::ST_STALE;
        end else begin
            check_status = gtht_pkg::ST_OK;
        end
    end
    assign check_ok = (check_status == gtht_pkg::ST_OK);

    // bitmap write port: clearing pass, allocate set, free clear
    always_comb begin
        vmem_we    = 1'b0;
        vmem_waddr = r_found_word;
        vmem_wdata = r_found_data | (WORD_W'(1) << r_found_bit);
        unique case (r_state)
            gtht_pkg::S_CLEAR: begin
                vmem_we    = 1'b1;
                vmem_waddr = r_clr_idx;
                vmem_wdata = '0;
            end
            gtht_pkg::S_ALLOC: begin
                vmem_we = 1'b1;
            end
            gtht_pkg::S_CHECK: begin
                vmem_we    = (r_cmd == gtht_pkg::CMD_FREE) && check_ok;
                vmem_waddr = r_key[BIT_W +: WA_W];
                vmem_wdata = r_vword & ~(WORD_W'(1) << r_key[BIT_W-1:0]);
            end
            default: begin
                vmem_we = 1'b0;
            end
        endcase
    end
    assign gmem_we = (r_state == gtht_pkg::S_ALLOC);

    always_ff @(posedge i_clk) begin
        if (vmem_we) begin
            r_vmem[vmem_waddr] <= vmem_wdata;
        end
        r_vword <= r_vmem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (gmem_we) begin
            r_gmem[found_slot] <= r_next_gen;
        end
        r_gword <= r_gmem[in_key[SLOT_W-1:0]];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gtht_pkg::S_CLEAR: begin
                if (r_clr_idx == LAST_WORD) begin
                    n_state = gtht_pkg::S_IDLE;
                end
            end
            gtht_pkg::S_IDLE: begin
                if (in_accept) begin
                    case (gtht_pkg::t_cmd'(i_command))
                        gtht_pkg::CMD_ALLOC: n_state = gtht_pkg::S_SCAN;
                        gtht_pkg::CMD_FREE, gtht_pkg::CMD_LOOKUP_HDL,
                        gtht_pkg::CMD_LOOKUP_SLOT: n_state = gtht_pkg::S_CHECK;
                        default: n_state = gtht_pkg::S_RESP;
                    endcase
                end
            end
            gtht_pkg::S_SCAN: begin
                if (r_data_vld && (|avail)) begin
                    n_state = gtht_pkg::S_ALLOC;
                end else if (r_data_vld && r_data_idx == LAST_WORD) begin
                    n_state = gtht_pkg::S_RESP;
                end
            end
            gtht_pkg::S_ALLOC: n_state = gtht_pkg::S_RESP;
            gtht_pkg::S_CHECK: n_state = gtht_pkg::S_RESP;
            gtht_pkg::S_RESP: begin
                if (out_free) begin
                    n_state = gtht_pkg::S_IDLE;
                end
            end
            default: n_state = gtht_pkg::S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_in_stall = (r_state != gtht_pkg::S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gtht_pkg::S_CLEAR;
            r_gen_max   <= gtht_pkg::GEN_MAX_RESET;
            r_next_gen  <= '0;
            r_used      <= '0;
            r_clr_idx   <= '0;
            r_scan_idx  <= '0;
            r_data_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_gen_max <= i_cfg_data;
            end
            if (r_state == gtht_pkg::S_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end

            if (r_state == gtht_pkg::S_SCAN) begin
                if (r_scan_idx != LAST_WORD) begin
                    r_scan_idx <= r_scan_idx + 1'b1;
                end
                r_data_vld <= (n_state == gtht_pkg::S_SCAN);
            end else begin
                r_scan_idx <= '0;
                r_data_vld <= 1'b0;
            end

            if (r_state == gtht_pkg::S_ALLOC) begin
                r_next_gen <= gen_adv;
                r_used     <= r_used + 1'b1;
            end
            if (r_state == gtht_pkg::S_CHECK && r_cmd == gtht_pkg::CMD_FREE
                    && check_ok && r_used != '0) begin
                r_used <= r_used - 1'b1;
            end

            if (r_state == gtht_pkg::S_RESP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_data_idx <= r_scan_idx;
        if (in_accept) begin
            r_cmd        <= gtht_pkg::t_cmd'(i_command);
            r_key        <= in_key;
            r_key_gen    <= i_handle[31:FIELD_W];
            r_res_status <= gtht_pkg::ST_OK;
            r_res_handle <= '0;
        end
        unique case (r_state)
            gtht_pkg::S_SCAN: begin
                if (r_data_vld && (|avail)) begin
                    r_found_word <= r_data_idx;
                    r_found_bit  <= gtht_pkg::first_set(avail);
                    r_found_data <= r_vword;
                end else if (r_data_vld && r_data_idx == LAST_WORD) begin
                    r_res_status <= gtht_pkg::ST_FULL;
                    r_res_handle <= '0;
                end
            end
            gtht_pkg::S_ALLOC: begin
                r_res_status <= gtht_pkg::ST_OK;
                r_res_handle <= {r_next_gen, found_slot_f};
            end
            gtht_pkg::S_CHECK: begin
                r_res_status <= check_status;
                r_res_handle <= check_ok ? {r_gword, r_key} : '0;
            end
            default: begin
            end
        endcase
        if (r_state == gtht_pkg::S_RESP && out_free) begin
            r_out_status <= r_res_status;
            r_out_handle <= r_res_handle;
            r_out_live   <= r_used;
        end
    end

    assign live_ext     = (CNT_W + LIVE_W)'(r_out_live);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_handle_out = r_out_handle;
    assign o_live_count = live_ext[LIVE_W-1:0];

    // live total never passes the table size
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_used} <= (CNT_W + 1)'(TABLE_DEPTH))
        else $error("live count above table depth");

    // a failed command never reports a handle
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != gtht_pkg::ST_OK) |-> (o_handle_out == '0))
        else $error("nonzero handle on failed command");

    // a new result beat appears only after the response step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == gtht_pkg::S_RESP))
        else $error("result beat without response step");

    // allocation always follows a successful scan hit
    a_alloc_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gtht_pkg::S_ALLOC) |-> ($past(r_state) == gtht_pkg::S_SCAN))
        else $error("allocate without scan");

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the generation-tagged handle table: a tracker class
// keeps its own copy of the slot table, predicts one answer per accepted
// command beat and compares each answer beat in order. Directed corner cases
// come first, then random phases under several idle/stall mixes and settings
// of the generation limit, including a run that fills the table.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH  = gtht_pkg::DEFAULT_TABLE_DEPTH;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 48;
    localparam int QUIET_LIMIT  = 4000;
    localparam int SHOW_LIMIT   = 10;
    // command values past CMD_COUNT behave as count
    localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;

    typedef struct {
        gtht_pkg::t_status status;
        logic [31:0]       handle;
        logic [10:0]       live;
    } t_table_answer;

    class handle_table_tracker;
        bit            slot_used[TABLE_DEPTH];
        logic [15:0]   slot_gen[TABLE_DEPTH];
        int            live_pos[TABLE_DEPTH];
        int            live_slots[$];
        logic [15:0]   next_gen;
        logic [15:0]   gen_limit;
        int unsigned   used;
        t_table_answer pending_answers[$];
        int            errors;

        function new();
            next_gen  = '0;
            gen_limit = gtht_pkg::GEN_MAX_RESET;
            used      = 0;
            errors    = 0;
            foreach (slot_used[k]) slot_used[k] = 1'b0;
        endfunction

        function gtht_pkg::t_status check_handle(logic [31:0] hdl);
            if (hdl[15:0] >= TABLE_DEPTH) return gtht_pkg::ST_BAD_SLOT;
            if (!slot_used[hdl[15:0]]) return gtht_pkg::ST_EMPTY;
            if (slot_gen[hdl[15:0]] != hdl[31:16]) return gtht_pkg::ST_STALE;
            return gtht_pkg::ST_OK;
        endfunction

        function t_table_answer predict_answer(logic [2:0] cmd, logic [31:0] hdl,
                                               logic [15:0] sidx);
            t_table_answer ans;
            int slot;
            int moved;
            ans.status = gtht_pkg::ST_OK;
            ans.handle = '0;
            slot = -1;
            case (cmd)
                gtht_pkg::CMD_ALLOC: begin
                    ans.status = gtht_pkg::ST_FULL;
                    for (int k = 0; k < TABLE_DEPTH && slot < 0; k++) begin
                        if (!slot_used[k]) slot = k;
                    end
                    if (slot >= 0) begin
                        ans.status      = gtht_pkg::ST_OK;
                        ans.handle      = {next_gen, 16'(slot)};
                        slot_used[slot] = 1'b1;
                        slot_gen[slot]  = next_gen;
                        // a limit lowered below next_gen still issues it once
                        next_gen        = (next_gen >= gen_limit) ? '0 : next_gen + 16'd1;
                        used++;
                        live_pos[slot]  = live_slots.size();
                        live_slots.push_back(slot);
                    end
                end
                gtht_pkg::CMD_FREE: begin
                    ans.status = check_handle(hdl);
                    if (ans.status == gtht_pkg::ST_OK) begin
                        slot            = int'(hdl[15:0]);
                        slot_used[slot] = 1'b0;
                        if (used > 0) used--;
                        moved                     = live_slots[live_slots.size() - 1];
                        live_slots[live_pos[slot]] = moved;
                        live_pos[moved]           = live_pos[slot];
                        void'(live_slots.pop_back());
                        ans.handle = hdl;
                    end
                end
                gtht_pkg::CMD_LOOKUP_HDL: begin
                    ans.status = check_handle(hdl);
                    if (ans.status == gtht_pkg::ST_OK) ans.handle = hdl;
                end
                gtht_pkg::CMD_LOOKUP_SLOT: begin
                    if (sidx >= TABLE_DEPTH) ans.status = gtht_pkg::ST_BAD_SLOT;
                    else if (!slot_used[sidx]) ans.status = gtht_pkg::ST_EMPTY;
                    else ans.handle = {slot_gen[sidx], sidx};
                end
                default: begin
                end
            endcase
            ans.live = 11'(used);
            return ans;
        endfunction

        function void accept_command(logic [2:0] cmd, logic [31:0] hdl, logic [15:0] sidx);
            pending_answers.push_back(predict_answer(cmd, hdl, sidx));
        endfunction

        function void check_answer(logic [2:0] st, logic [31:0] hdl, logic [10:0] live);
            t_table_answer exp;
            if (pending_answers.size() == 0) begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("unexpected answer: status %0d handle %h live %0d", st, hdl, live);
                return;
            end
            exp = pending_answers.pop_front();
            if (st !== exp.status || hdl !== exp.handle || live !== exp.live) begin
                errors++;
                if (errors <= SHOW_LIMIT)
                    $display("mismatch: exp st %0d hdl %h live %0d, got st %0d hdl %h live %0d",
                             exp.status, exp.handle, exp.live, st, hdl, live);
            end
        endfunction

        function int live_total();
            return live_slots.size();
        endfunction

        function logic [31:0] live_handle();
            int s;
            s = live_slots[$urandom_range(live_slots.size() - 1)];
            return {slot_gen[s], 16'(s)};
        endfunction
    endclass

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        cfg_we     = 1'b0;
    logic [15:0] cfg_data   = '0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [2:0]  command    = '0;
    logic [31:0] handle     = '0;
    logic [15:0] slot_index = '0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [2:0]  status;
    logic [31:0] handle_out;
    logic [10:0] live_count;

    handle_table_tracker tracker = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_request   = 1'b0;
    int quiet_cycles   = 0;

    generation_tagged_handle_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_command    (command),
        .i_handle     (handle),
        .i_slot_index (slot_index),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_status     (status),
        .o_handle_out (handle_out),
        .o_live_count (live_count)
    );

    always #1 clk = ~clk;

    // receiver: random stall, or a long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_request) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                out_stall <= 1'b0;
            end else begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall)
            tracker.check_answer(status, handle_out, live_count);
    end

    always @(posedge clk) begin
        if ((in_valid && in_stall === 1'b0) || (rst_n && out_valid === 1'b1 && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic offer_command(input logic [2:0] cmd, input logic [31:0] hdl,
                                 input logic [15:0] sidx);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        handle     <= hdl;
        slot_index <= sidx;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        tracker.accept_command(cmd, hdl, sidx);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (tracker.pending_answers.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_gen_max(input logic [15:0] limit);
        cfg_we   <= 1'b1;
        cfg_data <= limit;
        @(posedge clk);
        cfg_we   <= 1'b0;
        tracker.gen_limit = limit;
    endtask

    // mostly live handles, some stale, some empty slots, some out of range
    function automatic logic [31:0] pick_handle();
        int r;
        r = $urandom_range(99);
        if (tracker.live_total() != 0 && r < 65) return tracker.live_handle();
        if (tracker.live_total() != 0 && r < 80)
            return tracker.live_handle() ^ {16'($urandom_range(65535, 1)), 16'd0};
        if (r < 92) return {16'($urandom), 16'($urandom_range(TABLE_DEPTH - 1))};
        return $urandom;
    endfunction

    function automatic logic [15:0] pick_slot();
        int r;
        r = $urandom_range(99);
        if (tracker.live_total() != 0 && r < 55) return 16'(tracker.live_handle());
        if (r < 85) return 16'($urandom_range(TABLE_DEPTH - 1));
        return 16'($urandom);
    endfunction

    task automatic random_command(input int alloc_pct);
        int r;
        r = $urandom_range(99);
        if (r < alloc_pct) begin
            offer_command(gtht_pkg::CMD_ALLOC, $urandom, 16'($urandom));
        end else begin
            r = $urandom_range(99);
            if (r < 35) offer_command(gtht_pkg::CMD_FREE, pick_handle(), 16'($urandom));
            else if (r < 60)
                offer_command(gtht_pkg::CMD_LOOKUP_HDL, pick_handle(), 16'($urandom));
            else if (r < 85) offer_command(gtht_pkg::CMD_LOOKUP_SLOT, $urandom, pick_slot());
            else if (r < 95) offer_command(gtht_pkg::CMD_COUNT, $urandom, 16'($urandom));
            else offer_command(CMD_UNUSED_FIRST + 3'($urandom_range(2)), $urandom,
                               16'($urandom));
        end
    endtask

    task automatic run_phase(input int beats, input int idle_pct, input int stall_pct,
                             input int alloc_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (beats) random_command(alloc_pct);
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, field extremes, unused commands
        offer_command(gtht_pkg::CMD_COUNT, '0, '0);
        offer_command(CMD_UNUSED_FIRST + 3'd2, '1, '1);
        offer_command(gtht_pkg::CMD_LOOKUP_SLOT, '0, 16'd0);
        offer_command(gtht_pkg::CMD_LOOKUP_SLOT, '0, 16'(TABLE_DEPTH - 1));
        offer_command(gtht_pkg::CMD_LOOKUP_SLOT, '0, 16'(TABLE_DEPTH));
        offer_command(gtht_pkg::CMD_LOOKUP_SLOT, '0, 16'hFFFF);
        offer_command(gtht_pkg::CMD_FREE, '0, '0);
        offer_command(gtht_pkg::CMD_LOOKUP_HDL, '1, '0);
        offer_command(gtht_pkg::CMD_ALLOC, '1, '1);
        offer_command(gtht_pkg::CMD_ALLOC, '0, '0);
        offer_command(gtht_pkg::CMD_ALLOC, '0, '0);
        offer_command(gtht_pkg::CMD_LOOKUP_HDL, {16'd1, 16'd1}, '0);
        offer_command(gtht_pkg::CMD_LOOKUP_HDL, {16'd0, 16'd1}, '0);
        offer_command(gtht_pkg::CMD_LOOKUP_SLOT, '0, 16'd1);
        offer_command(gtht_pkg::CMD_FREE, {16'd5, 16'd1}, '0);
        offer_command(gtht_pkg::CMD_FREE, {16'd1, 16'd1}, '0);
        offer_command(gtht_pkg::CMD_FREE, {16'd1, 16'd1}, '0);
        offer_command(gtht_pkg::CMD_ALLOC, '0, '0);
        offer_command(CMD_UNUSED_FIRST, '0, '0);
        offer_command(CMD_UNUSED_FIRST + 3'd1, '0, '0);
        wait_idle();
        // next generation already past the new limit
        write_gen_max(16'd1);
        repeat (3) offer_command(gtht_pkg::CMD_ALLOC, '0, '0);
        wait_idle();
        write_gen_max(16'd0);
        repeat (2) offer_command(gtht_pkg::CMD_ALLOC, '0, '0);
        wait_idle();
        write_gen_max(16'hFFFF);

        run_phase(70, 0, 0, 55);
        hold_request = 1'b1;
        run_phase(70, 0, 0, 55);
        wait_idle();
        write_gen_max(16'($urandom_range(300, 2)));
        run_phase(120, 57, 0, 55);
        wait_idle();
        write_gen_max(16'd7);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (tracker.live_total() < TABLE_DEPTH) random_command(97);
        run_phase(40, 0, 0, 50);
        wait_idle();
        write_gen_max(16'($urandom));
        run_phase(60, 0, 57, 20);
        wait_idle();
        write_gen_max(16'd3);
        run_phase(60, 27, 27, 45);
        wait_idle();

        tracker.errors += tracker.pending_answers.size();
        if (tracker.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
